@@ sv/ple_pkg.sv @@
package ple_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_ERASE  = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]               kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [LEN_W-1:0]         length;
        logic                     is_empty;
        logic [1:0]               status;
    } t_rsp;

endpackage

@@ sv/ple_ram.sv @@
module ple_ram #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [ple_pkg::WORD_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [ple_pkg::WORD_W-1:0]  o_rdata
);

    logic [ple_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [ple_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ple_seq.sv @@
module ple_seq #(
    parameter int CAPACITY = 64,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ple_pkg::t_req               i_req,
    output logic                        o_busy,
    output logic                        o_strobe,
    output ple_pkg::t_rsp               o_rsp,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic [ple_pkg::WORD_W-1:0]  o_wdata,
    output logic                        o_re,
    output logic [AW-1:0]               o_raddr,
    input  logic [ple_pkg::WORD_W-1:0]  i_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    // Common compare width for count and position.
    localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    ple_pkg::t_req     r_req,   n_req;
    logic [AW-1:0]     r_ptr,   n_ptr;
    logic              r_strobe, n_strobe;
    ple_pkg::t_rsp     r_rsp,   n_rsp;

    logic                       w_done;
    logic [1:0]                 w_status;
    logic [ple_pkg::WORD_W-1:0] w_rdval;
    logic [XW-1:0]              w_cnt_x;
    logic [XW-1:0]              w_new_cnt_x;
    logic [XW-1:0]              w_pos_x;
    logic [XW-1:0]              w_rpos_x;
    logic [XW-1:0]              w_ptr_x;

    assign w_cnt_x  = XW'(r_count);
    assign w_pos_x  = XW'(i_req.position);
    assign w_rpos_x = XW'(r_req.position);
    assign w_ptr_x  = XW'(r_ptr);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_req    = r_req;
        n_ptr    = r_ptr;
        n_strobe = 1'b0;
        n_rsp    = r_rsp;
        w_done   = 1'b0;
        w_status = ple_pkg::ST_OK;
        w_rdval  = '0;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = '0;
        o_re     = 1'b0;
        o_raddr  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    case (i_req.kind)
                        ple_pkg::KIND_APPEND: begin
                            w_done = 1'b1;
                            if (w_cnt_x >= CAP_X) begin
                                w_status = ple_pkg::ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = r_count[AW-1:0];
                                o_wdata = i_req.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ple_pkg::KIND_INSERT: begin
                            if (w_cnt_x >= CAP_X) begin
                                w_done   = 1'b1;
                                w_status = ple_pkg::ST_FULL;
                            end else if (w_pos_x == '0 || w_pos_x > w_cnt_x + XW'(1)) begin
                                w_done   = 1'b1;
                                w_status = ple_pkg::ST_RANGE;
                            end else if (w_pos_x == w_cnt_x + XW'(1)) begin
                                w_done  = 1'b1;
                                o_we    = 1'b1;
                                o_waddr = r_count[AW-1:0];
                                o_wdata = i_req.value;
                                n_count = r_count + CW'(1);
                            end else begin
                                // Move entries up, starting from the last one.
                                o_re    = 1'b1;
                                o_raddr = AW'(w_cnt_x - XW'(1));
                                n_ptr   = r_count[AW-1:0];
                                n_state = S_SHIFT_UP;
                            end
                        end
                        ple_pkg::KIND_ERASE: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                                w_done   = 1'b1;
                                w_status = ple_pkg::ST_RANGE;
                            end else if (w_pos_x == w_cnt_x) begin
                                w_done  = 1'b1;
                                n_count = r_count - CW'(1);
                            end else begin
                                // Move entries down, starting right after the hole.
                                o_re    = 1'b1;
                                o_raddr = AW'(w_pos_x);
                                n_ptr   = AW'(w_pos_x - XW'(1));
                                n_state = S_SHIFT_DN;
                            end
                        end
                        default: begin
                            if (w_pos_x == '0 || w_pos_x > w_cnt_x) begin
                                w_done   = 1'b1;
                                w_status = ple_pkg::ST_RANGE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = AW'(w_pos_x - XW'(1));
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                o_we    = 1'b1;
                o_waddr = r_ptr;
                o_wdata = i_rdata;
                if (w_ptr_x == w_rpos_x) begin
                    n_state = S_INS_WR;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = AW'(w_ptr_x - XW'(2));
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_INS_WR: begin
                o_we    = 1'b1;
                o_waddr = AW'(w_rpos_x - XW'(1));
                o_wdata = r_req.value;
                n_count = r_count + CW'(1);
                w_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SHIFT_DN: begin
                o_we    = 1'b1;
                o_waddr = r_ptr;
                o_wdata = i_rdata;
                if (w_ptr_x + XW'(2) == w_cnt_x) begin
                    n_count = r_count - CW'(1);
                    w_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = AW'(w_ptr_x + XW'(2));
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            S_READ: begin
                w_rdval = i_rdata;
                w_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_new_cnt_x = XW'(n_count);
        if (w_done) begin
            n_strobe         = 1'b1;
            n_rsp.read_value = w_rdval;
            n_rsp.length     = w_new_cnt_x[ple_pkg::LEN_W-1:0];
            n_rsp.is_empty   = (n_count == '0);
            n_rsp.status     = w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_req <= n_req;
        r_ptr <= n_ptr;
        r_rsp <= n_rsp;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

@@ sv/positional_list_engine_core.sv @@
// Channel   Direction  Handshake                Payload
// request   in         i_start high, o_busy low i_req (kind, position, value)
// result    out        o_strobe, one cycle      o_rsp (read_value, length, is_empty, status)
//
// Every accepted item yields one result, shown with o_strobe for one cycle.
// Append, insert at the end, erase of the last entry and any rejected item give
// their result in the cycle after acceptance; a read gives it after the S_READ state.
// Any other insert or erase first shifts the entries between the position and the end,
// the memory moving one entry per cycle; an insert then writes the new word in S_INS_WR.
// Reset (synchronous, active low) empties the list; stored words are not cleared.
// The receiver cannot stall, so a new item may be accepted while a result is shown.

module positional_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ple_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_strobe,
    output ple_pkg::t_rsp o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Memory port wires between the sequencer and the entry store.
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [ple_pkg::WORD_W-1:0] w_wdata;
    logic                       w_re;
    logic [AW-1:0]              w_raddr;
    logic [ple_pkg::WORD_W-1:0] w_rdata;

    // The sequencer decodes each item, checks it against the current length and
    // walks the shift one entry per cycle: it reads one entry and writes the one
    // read in the previous cycle. Reads always run ahead of the writes to the
    // same address, so no forwarding is needed.
    ple_seq #(
        .CAPACITY(CAPACITY)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_strobe(o_strobe),
        .o_rsp   (o_rsp),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_re    (w_re),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    // The entry store: one write and one read port, read data registered.
    ple_ram #(
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

endmodule

@@ sv/ple_checker.sv @@
module ple_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input ple_pkg::t_req i_req,
    input logic          o_busy,
    input logic          o_strobe,
    input ple_pkg::t_rsp o_rsp
);

    // An accepted item either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_strobe))
        else $error("accepted item neither completed nor held busy");

    // A result only follows an accepted item or ongoing work.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(o_busy || i_start))
        else $error("result without a pending item");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.is_empty) |-> (o_rsp.length == '0))
        else $error("empty list with nonzero length");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.status != ple_pkg::ST_OK) |-> (o_rsp.read_value == '0))
        else $error("rejected item returned a word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_rsp.status == ple_pkg::ST_OK || o_rsp.status == ple_pkg::ST_FULL
                      || o_rsp.status == ple_pkg::ST_RANGE))
        else $error("undefined status code");

endmodule

bind positional_list_engine_core ple_checker u_ple_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_req   (i_req),
    .o_busy  (o_busy),
    .o_strobe(o_strobe),
    .o_rsp   (o_rsp)
);
